### src/pwcc_pkg.sv
// package for the polygon wall collision check unit
// command, status codes and fixed probe offsets; no dependencies
package pwcc_pkg;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_RECT  = 2'd1;
  localparam logic [1:0] CMD_VERT  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_QUERY = 2'd2;

  localparam int CoordW = 20;
  localparam logic signed [CoordW-1:0] PROBE_DX = 20'sd192;
  localparam logic signed [CoordW-1:0] PROBE_DY_LOW = 20'sd192;
  localparam logic signed [CoordW-1:0] PROBE_DY_HIGH = 20'sd448;

  typedef logic signed [CoordW-1:0] coord_t;
endpackage

### src/pwcc_if.sv
// valid/ready channel interfaces for the collision check unit
// depends on pwcc_pkg
interface pwcc_in_if import pwcc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  coord_t     x_coord;
  coord_t     y_coord;
  coord_t     ext_x;
  coord_t     ext_y;
  logic       last_vertex;
  modport source (output valid, cmd, x_coord, y_coord, ext_x, ext_y, last_vertex,
                  input ready);
  modport sink (input valid, cmd, x_coord, y_coord, ext_x, ext_y, last_vertex,
                output ready);
endinterface

interface pwcc_out_if ();
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;
  modport source (output valid, hit, status, input ready);
  modport sink (input valid, hit, status, output ready);
endinterface

### src/polygon_wall_collision_check_unit.sv
// polygon wall collision check unit: object store, vertex store, query walker
// store beats answer in the cycle after accept; a query walks the rectangles and the
// polygons vertex by vertex (polygons under three vertices are skipped),
// stopping at the first hit; one item at a time, next beat after the result leaves
// synchronous active-low reset clears counts and control; memories are not reset
// depends on pwcc_pkg and pwcc_if
module polygon_wall_collision_check_unit import pwcc_pkg::*; #(
  parameter int MAX_OBJECTS  = 64,
  parameter int MAX_VERTICES = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  pwcc_in_if.sink       in_ch,
  pwcc_out_if.source    out_ch
);
  localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int OCW = $clog2(MAX_OBJECTS + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * CoordW + 4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OREAD = 4'd1;
  localparam logic [3:0] S_OGOT  = 4'd2;
  localparam logic [3:0] S_RECT  = 4'd3;
  localparam logic [3:0] S_VREAD = 4'd4;
  localparam logic [3:0] S_VGOT  = 4'd5;
  localparam logic [3:0] S_EDGE  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_VUPD  = 4'd11;

  typedef struct packed {
    logic   is_poly;
    coord_t ox;
    coord_t oy;
    coord_t w;
    coord_t h;
    logic [VW-1:0] first;
    logic [VCW-1:0] total;
  } obj_t;

  obj_t obj_mem [MAX_OBJECTS];
  logic [2*CoordW-1:0] vert_mem [MAX_VERTICES];

  logic [3:0] state_r, state_nxt;
  logic [OCW-1:0] obj_cnt_r;
  logic [VCW-1:0] vfill_r;
  logic poly_open_r;
  logic out_valid_r, out_hit_r;
  logic [1:0] out_status_r;

  // object memory port
  logic o_we;
  logic [OW-1:0] o_waddr, o_raddr;
  obj_t o_wdata, o_rdata_r;
  // vertex memory port
  logic v_we;
  logic [VW-1:0] v_waddr, v_raddr;
  logic [2*CoordW-1:0] v_wdata, v_rdata_r;

  always_ff @(posedge clk) begin
    if (o_we) obj_mem[o_waddr] <= o_wdata;
    o_rdata_r <= obj_mem[o_raddr];
    if (v_we) vert_mem[v_waddr] <= v_wdata;
    v_rdata_r <= vert_mem[v_raddr];
  end

  // query walk state
  coord_t qx_r, qy_r;
  obj_t cur_r;
  logic [OCW-1:0] oi_r;
  logic [VCW-1:0] ei_r;
  logic signed [CoordW+1:0] xi_r, yi_r, xj_r, yj_r, x0_r, y0_r;
  logic [3:0] par_r;
  logic signed [PW-1:0] lhs_r [4];
  logic signed [PW-1:0] rhs_r [4];
  logic [3:0] straddle_r;
  logic dpos_r;
  logic have_j_r;

  logic signed [CoordW+1:0] px [4];
  logic signed [CoordW+1:0] py [4];
  always_comb begin
    px[0] = qx_r - PROBE_DX; py[0] = qy_r - PROBE_DY_LOW;
    px[1] = qx_r - PROBE_DX; py[1] = qy_r - PROBE_DY_HIGH;
    px[2] = qx_r + PROBE_DX; py[2] = qy_r - PROBE_DY_LOW;
    px[3] = qx_r + PROBE_DX; py[3] = qy_r - PROBE_DY_HIGH;
  end

  logic acc;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.hit = out_hit_r;
  assign out_ch.status = out_status_r;

  logic rect_hit;
  logic signed [CoordW+1:0] cur_ox, cur_oy;
  logic [VCW:0] vaddr_sum;
  always_comb begin
    cur_ox = cur_r.ox;
    cur_oy = cur_r.oy;
    rect_hit = 1'b0;
    if (cur_r.w > 0 && cur_r.h > 0)
      for (int p = 0; p < 4; p++)
        if (px[p] >= cur_ox && px[p] <= cur_ox + cur_r.w &&
            py[p] >= cur_oy && py[p] <= cur_oy + cur_r.h)
          rect_hit = 1'b1;
    vaddr_sum = {1'b0, cur_r.first} + {1'b0, ei_r};
  end

  logic [3:0] crossing;
  always_comb begin
    for (int p = 0; p < 4; p++)
      crossing[p] = straddle_r[p] &&
                    (dpos_r ? (lhs_r[p] < rhs_r[p]) : (lhs_r[p] > rhs_r[p]));
  end

  always_comb begin
    state_nxt = state_r;
    o_we = 1'b0; o_waddr = '0; o_wdata = o_rdata_r;
    o_raddr = oi_r[OW-1:0];
    v_we = 1'b0; v_waddr = vfill_r[VW-1:0];
    v_wdata = {in_ch.ext_x, in_ch.ext_y};
    v_raddr = vaddr_sum[VW-1:0];
    case (state_r)
      S_IDLE: begin
        o_raddr = OW'(obj_cnt_r - 1'b1);
        if (acc) begin
          case (in_ch.cmd)
            CMD_RECT: if (obj_cnt_r < OCW'(MAX_OBJECTS)) begin
              o_we = 1'b1; o_waddr = obj_cnt_r[OW-1:0];
              o_wdata = '{is_poly: 1'b0, ox: in_ch.x_coord, oy: in_ch.y_coord,
                          w: in_ch.ext_x, h: in_ch.ext_y, first: '0, total: '0};
            end
            CMD_VERT: begin
              if (!poly_open_r) begin
                if (obj_cnt_r < OCW'(MAX_OBJECTS) && vfill_r < VCW'(MAX_VERTICES)) begin
                  o_we = 1'b1; o_waddr = obj_cnt_r[OW-1:0];
                  o_wdata = '{is_poly: 1'b1, ox: in_ch.x_coord, oy: in_ch.y_coord,
                              w: '0, h: '0, first: vfill_r[VW-1:0], total: VCW'(1)};
                  v_we = 1'b1;
                end
              end else if (vfill_r < VCW'(MAX_VERTICES)) begin
                v_we = 1'b1;
                state_nxt = S_VUPD;
              end
            end
            CMD_QUERY: state_nxt = S_OREAD;
            default: ;
          endcase
        end
      end
      S_VUPD: begin
        // read-modify-write of the open polygon's vertex count
        o_we = 1'b1; o_waddr = OW'(obj_cnt_r - 1'b1);
        o_wdata.total = o_rdata_r.total + 1'b1;
        state_nxt = S_IDLE;
      end
      S_OREAD: state_nxt = (oi_r >= obj_cnt_r) ? S_OUT : S_OGOT;
      // polygons under three vertices can never hit, skip them
      S_OGOT: state_nxt = o_rdata_r.is_poly ?
                          ((o_rdata_r.total < VCW'(3)) ? S_NEXT : S_VREAD) : S_RECT;
      S_RECT: state_nxt = rect_hit ? S_OUT : S_NEXT;
      S_VREAD: state_nxt = S_VGOT;
      S_VGOT: state_nxt = have_j_r ? S_EDGE : S_VREAD;
      S_EDGE: state_nxt = S_MUL;
      S_MUL: state_nxt = S_CMP;
      S_CMP: begin
        if (ei_r == cur_r.total - 1'b1)
          state_nxt = ((par_r ^ crossing) != 4'd0) ? S_OUT : S_NEXT;
        else state_nxt = S_VREAD;
      end
      S_NEXT: state_nxt = S_OREAD;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic signed [CoordW+1:0] vx_abs, vy_abs;
  always_comb begin
    vx_abs = cur_ox + $signed(v_rdata_r[2*CoordW-1:CoordW]);
    vy_abs = cur_oy + $signed(v_rdata_r[CoordW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      obj_cnt_r <= '0;
      vfill_r <= '0;
      poly_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (acc && in_ch.cmd != CMD_QUERY) begin
        out_valid_r <= 1'b1; out_hit_r <= 1'b0;
        case (in_ch.cmd)
          CMD_CLEAR: begin
            obj_cnt_r <= '0; vfill_r <= '0; poly_open_r <= 1'b0;
            out_status_r <= ST_OK;
          end
          CMD_RECT: begin
            poly_open_r <= 1'b0;
            if (obj_cnt_r < OCW'(MAX_OBJECTS)) begin
              obj_cnt_r <= obj_cnt_r + 1'b1;
              out_status_r <= ST_OK;
            end else out_status_r <= ST_FULL;
          end
          CMD_VERT: begin
            if (!poly_open_r) begin
              if (obj_cnt_r < OCW'(MAX_OBJECTS) && vfill_r < VCW'(MAX_VERTICES)) begin
                obj_cnt_r <= obj_cnt_r + 1'b1;
                vfill_r <= vfill_r + 1'b1;
                poly_open_r <= !in_ch.last_vertex;
                out_status_r <= ST_OK;
              end else out_status_r <= ST_FULL;
            end else begin
              if (vfill_r < VCW'(MAX_VERTICES)) begin
                vfill_r <= vfill_r + 1'b1;
                out_status_r <= ST_OK;
              end else out_status_r <= ST_FULL;
              if (in_ch.last_vertex) poly_open_r <= 1'b0;
            end
          end
          default: out_status_r <= ST_OK;
        endcase
      end
      if (state_r == S_RECT && rect_hit) out_hit_r <= 1'b1;
      if (state_r == S_CMP && ei_r == cur_r.total - 1'b1 && (par_r ^ crossing) != 4'd0)
        out_hit_r <= 1'b1;
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1; out_status_r <= ST_QUERY;
      end
      if (acc && in_ch.cmd == CMD_QUERY) out_hit_r <= 1'b0;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        qx_r <= in_ch.x_coord; qy_r <= in_ch.y_coord; oi_r <= '0;
      end
      S_OGOT: begin
        cur_r <= o_rdata_r;
        // start at the last vertex so the closing edge comes first
        ei_r <= o_rdata_r.total - 1'b1;
        have_j_r <= 1'b0; par_r <= '0;
      end
      S_VGOT: begin
        xi_r <= vx_abs; yi_r <= vy_abs;
        if (!have_j_r) begin
          xj_r <= vx_abs; yj_r <= vy_abs; have_j_r <= 1'b1; ei_r <= '0;
        end
      end
      S_EDGE: begin
        for (int p = 0; p < 4; p++) begin
          straddle_r[p] <= (yi_r > py[p]) != (yj_r > py[p]);
          lhs_r[p] <= PW'(px[p] - xi_r);
          rhs_r[p] <= PW'(py[p] - yi_r);
        end
        x0_r <= yj_r - yi_r;
        y0_r <= xj_r - xi_r;
        dpos_r <= yj_r > yi_r;
      end
      S_MUL: begin
        for (int p = 0; p < 4; p++) begin
          lhs_r[p] <= PW'(lhs_r[p] * x0_r);
          rhs_r[p] <= PW'(rhs_r[p] * y0_r);
        end
      end
      S_CMP: begin
        par_r <= par_r ^ crossing;
        xj_r <= xi_r; yj_r <= yi_r;
        ei_r <= ei_r + 1'b1;
      end
      S_NEXT: oi_r <= oi_r + 1'b1;
      default: ;
    endcase
  end
endmodule

### sim/polygon_wall_collision_check_unit_test.sv
// testbench for the polygon wall collision check unit: drives store and query beats,
// predicts hit/status from its own object and vertex store model, checks each result
// depends on pwcc_pkg, pwcc_if and the unit itself
`timescale 1ns / 1ps

module polygon_wall_collision_check_unit_test;
  import pwcc_pkg::*;

  localparam int NOBJ = 64;
  localparam int NVERT = 512;

  typedef struct packed {
    logic [1:0] cmd;
    coord_t     xc;
    coord_t     yc;
    coord_t     ex;
    coord_t     ey;
    logic       last;
  } shape_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pwcc_in_if  in_ch ();
  pwcc_out_if out_ch ();

  polygon_wall_collision_check_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow store
  int          obj_count;
  bit          obj_poly [NOBJ];
  longint      obj_x [NOBJ];
  longint      obj_y [NOBJ];
  longint      obj_w [NOBJ];
  longint      obj_h [NOBJ];
  int          poly_first [NOBJ];
  int          poly_total [NOBJ];
  longint      vtx_x [NVERT];
  longint      vtx_y [NVERT];
  int          vtx_fill;
  bit          poly_open;

  shape_cmd_t  pending_cmds [$];
  verdict_t    expected_verdicts [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          stim_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit probe_hits_poly(int o, longint px, longint py);
    bit odd;
    int j;
    longint xi, yi, xj, yj, d, lhs, rhs;
    odd = 1'b0;
    j = poly_total[o] - 1;
    for (int i = 0; i < poly_total[o]; i++) begin
      xi = obj_x[o] + vtx_x[poly_first[o] + i];
      yi = obj_y[o] + vtx_y[poly_first[o] + i];
      xj = obj_x[o] + vtx_x[poly_first[o] + j];
      yj = obj_y[o] + vtx_y[poly_first[o] + j];
      if ((yi > py) != (yj > py)) begin
        d = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic bit probe_hits_rect(int o, longint px, longint py);
    if (obj_w[o] <= 0 || obj_h[o] <= 0) return 1'b0;
    return px >= obj_x[o] && px <= obj_x[o] + obj_w[o] &&
           py >= obj_y[o] && py <= obj_y[o] + obj_h[o];
  endfunction

  function automatic bit foot_collides(longint fx, longint fy);
    longint px [4];
    longint py [4];
    px[0] = fx - PROBE_DX; py[0] = fy - PROBE_DY_LOW;
    px[1] = fx - PROBE_DX; py[1] = fy - PROBE_DY_HIGH;
    px[2] = fx + PROBE_DX; py[2] = fy - PROBE_DY_LOW;
    px[3] = fx + PROBE_DX; py[3] = fy - PROBE_DY_HIGH;
    for (int o = 0; o < obj_count; o++)
      for (int p = 0; p < 4; p++)
        if (obj_poly[o] ? probe_hits_poly(o, px[p], py[p]) : probe_hits_rect(o, px[p], py[p]))
          return 1'b1;
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(shape_cmd_t c);
    verdict_t v;
    int o;
    v = '0;
    v.status = ST_OK;
    case (c.cmd)
      CMD_CLEAR: begin
        obj_count = 0; vtx_fill = 0; poly_open = 1'b0;
      end
      CMD_RECT: begin
        poly_open = 1'b0;
        if (obj_count >= NOBJ) v.status = ST_FULL;
        else begin
          obj_poly[obj_count] = 1'b0;
          obj_x[obj_count] = c.xc; obj_y[obj_count] = c.yc;
          obj_w[obj_count] = c.ex; obj_h[obj_count] = c.ey;
          obj_count++;
        end
      end
      CMD_VERT: begin
        if (!poly_open) begin
          if (obj_count >= NOBJ || vtx_fill >= NVERT) v.status = ST_FULL;
          else begin
            o = obj_count;
            obj_poly[o] = 1'b1;
            obj_x[o] = c.xc; obj_y[o] = c.yc;
            poly_first[o] = vtx_fill; poly_total[o] = 1;
            vtx_x[vtx_fill] = c.ex; vtx_y[vtx_fill] = c.ey;
            vtx_fill++;
            obj_count++;
            poly_open = ~c.last;
          end
        end else begin
          if (vtx_fill >= NVERT) v.status = ST_FULL;
          else begin
            vtx_x[vtx_fill] = c.ex; vtx_y[vtx_fill] = c.ey;
            vtx_fill++;
            poly_total[obj_count - 1]++;
          end
          if (c.last) poly_open = 1'b0;
        end
      end
      default: begin
        v.hit = foot_collides(c.xc, c.yc);
        v.status = ST_QUERY;
      end
    endcase
    return v;
  endfunction

  // driver: present queue head at falling edge, hold until taken
  logic drv_valid = 1'b0;
  shape_cmd_t drv_cmd = '0;
  assign in_ch.valid = drv_valid;
  assign in_ch.cmd = drv_cmd.cmd;
  assign in_ch.x_coord = drv_cmd.xc;
  assign in_ch.y_coord = drv_cmd.yc;
  assign in_ch.ext_x = drv_cmd.ex;
  assign in_ch.ext_y = drv_cmd.ey;
  assign in_ch.last_vertex = drv_cmd.last;

  logic sink_ready = 1'b0;
  assign out_ch.ready = sink_ready;

  bit in_taken;
  always @(posedge clk) in_taken <= rst_n && drv_valid && in_ch.ready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!drv_valid || in_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          drv_cmd <= pending_cmds.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
      sink_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // predictor runs on accepted input beats, checker on accepted result beats
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && drv_valid && in_ch.ready)
      expected_verdicts.push_back(predict_verdict(drv_cmd));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.hit !== want.hit) report_mismatch("hit", out_ch.hit, want.hit);
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  function automatic coord_t rnd_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t near_coord(int span);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic shape_cmd_t mk(logic [1:0] c, coord_t x, coord_t y, coord_t ex,
                                     coord_t ey, logic l);
    shape_cmd_t s;
    s.cmd = c; s.xc = x; s.yc = y; s.ex = ex; s.ey = ey; s.last = l;
    return s;
  endfunction

  task automatic add_random_polygon();
    int n;
    coord_t ox, oy;
    n = $urandom_range(1, 7);
    ox = near_coord(3000); oy = near_coord(3000);
    for (int k = 0; k < n; k++)
      pending_cmds.push_back(mk(CMD_VERT, ox, oy, near_coord(1500), near_coord(1500),
                                k == n - 1 && $urandom_range(9) != 0));
  endtask

  task automatic queue_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 3) pending_cmds.push_back(mk(CMD_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                                         rnd_coord(), 1'($urandom_range(1))));
    else if (r < 18) pending_cmds.push_back(mk(CMD_RECT, near_coord(3000), near_coord(3000),
                                               near_coord(1200), near_coord(1200),
                                               1'($urandom_range(1))));
    else if (r < 30) add_random_polygon();
    else if (r < 35) pending_cmds.push_back(mk(2'($urandom_range(1, 3)), rnd_coord(),
                                               rnd_coord(), rnd_coord(), rnd_coord(),
                                               1'($urandom_range(1))));
    else pending_cmds.push_back(mk(CMD_QUERY, near_coord(3500), near_coord(3500),
                                   rnd_coord(), rnd_coord(), 1'($urandom_range(1))));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || drv_valid || expected_verdicts.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    coord_t maxc, minc;
    maxc = coord_t'(20'h7ffff);
    minc = coord_t'(20'h80000);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, box edges, degenerate shapes, open polygon
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_RECT, 0, 0, 100, 100, 1'b1));
    pending_cmds.push_back(mk(CMD_QUERY, 192, 192, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, -92, 292, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, -93, 293, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_RECT, 500, 500, 0, 100, 1'b0));
    pending_cmds.push_back(mk(CMD_RECT, minc, minc, maxc, maxc, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, maxc, maxc, maxc, maxc, 1'b1));
    pending_cmds.push_back(mk(CMD_QUERY, minc, minc, minc, minc, 1'b0));
    pending_cmds.push_back(mk(CMD_CLEAR, maxc, minc, maxc, minc, 1'b1));
    pending_cmds.push_back(mk(CMD_VERT, 1000, 1000, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, 1000, 1000, 800, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, 1400, 1400, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, 1000, 1000, 800, 800, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, 1600, 1500, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_RECT, 5000, 5000, 10, 10, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, -3000, 2000, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, 0, 0, 600, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, 0, 0, 300, -600, 1'b1));
    pending_cmds.push_back(mk(CMD_QUERY, -2700, 1900, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, maxc, minc, maxc, minc, 1'b1));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 1'b1));
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    wait_drained();

    // fill the object store, then the vertex store, to hit both full cases
    for (int k = 0; k < 66; k++)
      pending_cmds.push_back(mk(CMD_RECT, near_coord(3000), near_coord(3000),
                                near_coord(400), near_coord(400), 1'b0));
    pending_cmds.push_back(mk(CMD_VERT, 0, 0, 5, 5, 1'b0));
    pending_cmds.push_back(mk(CMD_QUERY, near_coord(3000), near_coord(3000), 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    for (int k = 0; k < 520; k++)
      pending_cmds.push_back(mk(CMD_VERT, near_coord(2000), near_coord(2000),
                                near_coord(600), near_coord(600), (k % 9) == 8 || k == 515));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 1'b0));
    pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    wait_drained();

    // random phases over idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 15 : 47) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 15 : 47) : 0;
      for (int k = 0; k < 30; k++) queue_random_item();
      wait_drained();
    end
    idle_pct = 0; stall_pct = 0;
    stim_done = 1'b1;
    wait_drained();
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
